FILE: rtl/core/baatan_pkg.sv
`default_nettype none

package baatan_pkg;

    localparam int TABLE_SIZE = 2000;
    localparam int COORD_BITS = 32;
    localparam int ANGLE_BITS = 16;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int TS_W  = $clog2(TABLE_SIZE + 1);
    localparam int NUM_W = COORD_BITS + TS_W;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);
    localparam logic [NUM_W-1:0] NUM_SCALE = NUM_W'(TABLE_SIZE);

    localparam logic [ANGLE_BITS-1:0] ANG_HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] ANG_QUARTER = ANG_HALF >> 1;
    localparam logic [ANGLE_BITS-1:0] ANG_EIGHTH  = ANG_HALF >> 2;

    localparam int          FRAC_BITS  = 60;
    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam int          SERIES_CAP = 200;

    typedef enum logic [1:0] {
        CLS_ZERO_Y,
        CLS_DIAG,
        CLS_ZERO_X,
        CLS_GENERAL
    } cls_t;

    typedef struct packed {
        cls_t cls;
        logic swap;
        logic xneg;
        logic yneg;
    } side_t;

    typedef logic [ANGLE_BITS-1:0] rom_word_t;

    function automatic logic [63:0] mul_q60(input logic [63:0] u, input logic [63:0] v);
        logic [127:0] p;
        p = {64'd0, u} * {64'd0, v};
        return p[123:60];
    endfunction

    function automatic logic [63:0] frac_div(input logic [63:0] n, input logic [63:0] d,
                                             input int bits);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = n;
        for (int k = 0; k < bits; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] long_div(input logic [63:0] t, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[62:0], t[k]};
            if (r >= d) begin
                r = r - d;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // Series for atan(a/b) in Q60, scaled to the binary angle.
    function automatic rom_word_t atan_entry(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] a2;
        logic [63:0] s2;
        logic [63:0] pref;
        logic [63:0] yq;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] n;
        logic [63:0] res;
        if (a == 64'd0) begin
            return '0;
        end
        a2   = a * a;
        s2   = a2 + b * b;
        pref = frac_div(a * b, s2, FRAC_BITS);
        yq   = frac_div(a2, s2, FRAC_BITS);
        term = 64'd1 << FRAC_BITS;
        sum  = term;
        n    = 64'd1;
        while (n <= 64'(SERIES_CAP) && term != 64'd0) begin
            term = mul_q60(term, yq);
            term = term - long_div(term, 2 * n + 64'd1);
            sum  = sum + term;
            n    = n + 64'd1;
        end
        res = frac_div(mul_q60(pref, sum), PI_Q60, ANGLE_BITS - 1);
        return res[ANGLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/baatan_div.sv
`default_nettype none

module baatan_div
    import baatan_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [NUM_W-1:0]      in_num,
    input  wire logic [COORD_BITS-1:0] in_den,
    input  wire side_t                 in_side,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [IDX_W-1:0]           out_quo,
    output side_t                      out_side
);

    logic [IDX_W-1:0]      vld_reg;
    logic [NUM_W-1:0]      rem_reg  [IDX_W];
    logic [COORD_BITS-1:0] den_reg  [IDX_W];
    logic [IDX_W-1:0]      quo_reg  [IDX_W];
    side_t                 side_reg [IDX_W];

    logic [IDX_W-1:0]      vld_src;
    logic [NUM_W-1:0]      rem_src  [IDX_W];
    logic [COORD_BITS-1:0] den_src  [IDX_W];
    logic [IDX_W-1:0]      quo_src  [IDX_W];
    side_t                 side_src [IDX_W];

    logic [IDX_W-1:0]      stage_rdy;
    logic [IDX_W-1:0]      down_rdy;
    logic [NUM_W-1:0]      trial    [IDX_W];
    logic [NUM_W-1:0]      rem_next [IDX_W];
    logic [IDX_W-1:0]      quo_next [IDX_W];

    for (genvar s = 0; s < IDX_W; s++) begin : g_link
        if (s == 0) begin : g_first
            assign vld_src[s]  = in_valid;
            assign rem_src[s]  = in_num;
            assign den_src[s]  = in_den;
            assign quo_src[s]  = '0;
            assign side_src[s] = in_side;
        end else begin : g_rest
            assign vld_src[s]  = vld_reg[s-1];
            assign rem_src[s]  = rem_reg[s-1];
            assign den_src[s]  = den_reg[s-1];
            assign quo_src[s]  = quo_reg[s-1];
            assign side_src[s] = side_reg[s-1];
        end
        if (s == IDX_W - 1) begin : g_tail
            assign down_rdy[s] = out_ready;
        end else begin : g_mid
            assign down_rdy[s] = stage_rdy[s+1];
        end
    end

    // Each stage settles one quotient bit, most significant first.
    always_comb
    begin
        for (int s = 0; s < IDX_W; s++) begin
            trial[s]     = NUM_W'(den_src[s]) << (IDX_W - 1 - s);
            rem_next[s]  = rem_src[s];
            quo_next[s]  = quo_src[s];
            if (rem_src[s] >= trial[s]) begin
                rem_next[s]              = rem_src[s] - trial[s];
                quo_next[s][IDX_W-1-s]   = 1'b1;
            end
            stage_rdy[s] = !vld_reg[s] || down_rdy[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            for (int s = 0; s < IDX_W; s++) begin
                if (stage_rdy[s]) begin
                    vld_reg[s] <= vld_src[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < IDX_W; s++) begin
            if (stage_rdy[s] && vld_src[s]) begin
                rem_reg[s]  <= rem_next[s];
                den_reg[s]  <= den_src[s];
                quo_reg[s]  <= quo_next[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign in_ready  = stage_rdy[0];
    assign out_valid = vld_reg[IDX_W-1];
    assign out_quo   = quo_reg[IDX_W-1];
    assign out_side  = side_reg[IDX_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/baatan_rom.sv
`default_nettype none

module baatan_rom
    import baatan_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output rom_word_t             rd_data
);

    rom_word_t rom_mem [TABLE_SIZE];
    rom_word_t rd_data_reg;

    initial
    begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
            rom_mem[i] = atan_entry(64'(i), 64'(TABLE_SIZE));
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            rd_data_reg <= rom_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/binary_angle_atan2.sv
`default_nettype none

// Four-quadrant arctangent returning a binary angle, where a full turn is
// 2^ANGLE_BITS. A transaction on the vector channel (vec_valid, vec_stall)
// carries signed vec_x and vec_y; each one yields exactly one transaction on
// the angle channel (angle_valid, angle_stall), in order.
// The pipeline has IDX_W + 4 register stages: a magnitude stage, a ratio
// set-up stage, a stage per quotient bit in the pipelined restoring divider
// (IDX_W bits, eleven for a 2000-entry table), a stage for the synchronous
// arctangent ROM read and a last stage for quadrant mirroring. angle_valid
// and angle come straight from the registers of the mirroring stage.
// Throughput is one transaction per cycle while angle_stall is low; the
// divider stages and the single ROM read port each take a new operand
// every cycle unless a stall holds them.
// Every stage holds its own valid bit, so bubbles close up: while a result
// waits under angle_stall, earlier stages keep filling and vec_stall rises
// only once the whole pipeline is full. A stalled result is held unchanged.
// Reset clears every valid bit; the ROM contents are fixed and need no fill.

module binary_angle_atan2
    import baatan_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  vec_valid,
    output logic                       vec_stall,
    input  wire logic [COORD_BITS-1:0] vec_x,
    input  wire logic [COORD_BITS-1:0] vec_y,
    output logic                       angle_valid,
    input  wire logic                  angle_stall,
    output logic [ANGLE_BITS-1:0]      angle
);

    logic                  a_vld_reg;
    logic [COORD_BITS-1:0] a_ax_reg;
    logic [COORD_BITS-1:0] a_ay_reg;
    logic                  a_xneg_reg;
    logic                  a_yneg_reg;
    logic [COORD_BITS-1:0] a_ax_next;
    logic [COORD_BITS-1:0] a_ay_next;
    logic                  a_rdy;

    logic                  b_vld_reg;
    logic [NUM_W-1:0]      b_num_reg;
    logic [COORD_BITS-1:0] b_den_reg;
    side_t                 b_side_reg;
    logic [NUM_W-1:0]      b_num_next;
    logic [COORD_BITS-1:0] b_den_next;
    side_t                 b_side_next;
    logic                  b_rdy;

    logic                  div_in_ready;
    logic                  div_out_valid;
    logic [IDX_W-1:0]      div_quo;
    side_t                 div_side;

    logic                  c_vld_reg;
    side_t                 c_side_reg;
    logic [IDX_W-1:0]      c_idx;
    logic                  c_rdy;
    rom_word_t             rom_data;

    logic                  d_vld_reg;
    logic [ANGLE_BITS-1:0] d_angle_reg;
    logic [ANGLE_BITS-1:0] d_angle_next;
    logic [ANGLE_BITS-1:0] d_first;
    logic [ANGLE_BITS-1:0] d_mirror;
    logic                  d_rdy;

    assign d_rdy     = !d_vld_reg || !angle_stall;
    assign c_rdy     = !c_vld_reg || d_rdy;
    assign b_rdy     = !b_vld_reg || div_in_ready;
    assign a_rdy     = !a_vld_reg || b_rdy;
    assign vec_stall = !a_rdy;

    always_comb
    begin
        a_ax_next = vec_x[COORD_BITS-1] ? (~vec_x + 1'b1) : vec_x;
        a_ay_next = vec_y[COORD_BITS-1] ? (~vec_y + 1'b1) : vec_y;
    end

    always_comb
    begin
        b_side_next.swap = a_ay_reg > a_ax_reg;
        b_side_next.xneg = a_xneg_reg;
        b_side_next.yneg = a_yneg_reg;
        priority if (a_ay_reg == '0) begin
            b_side_next.cls = CLS_ZERO_Y;
        end else if (a_ay_reg == a_ax_reg) begin
            b_side_next.cls = CLS_DIAG;
        end else if (a_ax_reg == '0) begin
            b_side_next.cls = CLS_ZERO_X;
        end else begin
            b_side_next.cls = CLS_GENERAL;
        end
        b_den_next = b_side_next.swap ? a_ay_reg : a_ax_reg;
        b_num_next = NUM_W'(b_side_next.swap ? a_ax_reg : a_ay_reg) * NUM_SCALE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end else begin
            if (a_rdy) begin
                a_vld_reg <= vec_valid;
            end
            if (b_rdy) begin
                b_vld_reg <= a_vld_reg;
            end
            if (c_rdy) begin
                c_vld_reg <= div_out_valid;
            end
            if (d_rdy) begin
                d_vld_reg <= c_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && vec_valid) begin
            a_ax_reg   <= a_ax_next;
            a_ay_reg   <= a_ay_next;
            a_xneg_reg <= vec_x[COORD_BITS-1];
            a_yneg_reg <= vec_y[COORD_BITS-1];
        end
        if (b_rdy && a_vld_reg) begin
            b_num_reg  <= b_num_next;
            b_den_reg  <= b_den_next;
            b_side_reg <= b_side_next;
        end
        if (c_rdy && div_out_valid) begin
            c_side_reg <= div_side;
        end
        if (d_rdy && c_vld_reg) begin
            d_angle_reg <= d_angle_next;
        end
    end

    baatan_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_vld_reg),
        .in_ready  (div_in_ready),
        .in_num    (b_num_reg),
        .in_den    (b_den_reg),
        .in_side   (b_side_reg),
        .out_valid (div_out_valid),
        .out_ready (c_rdy),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    assign c_idx = (div_quo > IDX_LAST) ? IDX_LAST : div_quo;

    baatan_rom u_rom (
        .clk     (clk),
        .rd_en   (c_rdy),
        .rd_addr (c_idx),
        .rd_data (rom_data)
    );

    always_comb
    begin
        unique case (c_side_reg.cls)
            CLS_ZERO_Y:  d_first = '0;
            CLS_DIAG:    d_first = ANG_EIGHTH;
            CLS_ZERO_X:  d_first = ANG_QUARTER;
            CLS_GENERAL: d_first = c_side_reg.swap ? (ANG_QUARTER - rom_data) : rom_data;
        endcase
        d_mirror     = c_side_reg.xneg ? (ANG_HALF - d_first) : d_first;
        d_angle_next = c_side_reg.yneg ? (~d_mirror + 1'b1) : d_mirror;
    end

    assign angle_valid = d_vld_reg;
    assign angle       = d_angle_reg;

endmodule

`default_nettype wire

FILE: tb/tb_binary_angle_atan2.sv
`default_nettype none

module tb_binary_angle_atan2;
    import baatan_pkg::*;

    localparam int RANDOM_VECTORS = 1200;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 32;
    localparam int FIRST_HOLD_OFF = 60;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [COORD_BITS-1:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_BITS-1:0] C_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  known;
        logic [ANGLE_BITS-1:0] angle;
    } vector_case_t;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [ANGLE_BITS-1:0] angle;
    } angle_expect_t;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_HEAVY,
        RX_PERIODIC,
        RX_HOLD_OFF
    } rx_mode_t;

    localparam int N_DIRECTED = 25;
    localparam vector_case_t DIRECTED_VECTORS [N_DIRECTED] = '{
        '{32'd0,         32'd0,         1'b1, 16'd0},
        '{32'd5,         32'd0,         1'b1, 16'd0},
        '{32'hFFFF_FFFB, 32'd0,         1'b1, 16'd32768},
        '{32'd0,         32'd5,         1'b1, 16'd16384},
        '{32'd0,         32'hFFFF_FFFB, 1'b1, 16'd49152},
        '{32'd5,         32'd5,         1'b1, 16'd8192},
        '{32'hFFFF_FFFB, 32'd5,         1'b1, 16'd24576},
        '{32'hFFFF_FFFB, 32'hFFFF_FFFB, 1'b1, 16'd40960},
        '{32'd5,         32'hFFFF_FFFB, 1'b1, 16'd57344},
        '{C_MIN,         32'd0,         1'b1, 16'd32768},
        '{32'd0,         C_MIN,         1'b1, 16'd49152},
        '{C_MIN,         C_MIN,         1'b1, 16'd40960},
        '{C_MAX,         C_MAX,         1'b1, 16'd8192},
        '{C_MAX,         32'hFFFF_FFFF, 1'b1, 16'd0},
        '{32'h8000_0001, 32'hFFFF_FFFF, 1'b1, 16'd32768},
        '{C_MAX,         32'd1,         1'b0, 16'd0},
        '{32'd1,         C_MAX,         1'b0, 16'd0},
        '{C_MIN,         C_MAX,         1'b0, 16'd0},
        '{C_MAX,         C_MIN,         1'b0, 16'd0},
        '{C_MAX,         32'h7FFF_FFFE, 1'b0, 16'd0},
        '{32'd3,         32'd4,         1'b0, 16'd0},
        '{32'hFFFF_FFFC, 32'd3,         1'b0, 16'd0},
        '{32'd1000,      32'hFFFF_FFFF, 1'b0, 16'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 16'd0},
        '{C_MIN,         32'd1,         1'b0, 16'd0}
    };

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  vec_valid   = 1'b0;
    logic                  vec_stall;
    logic [COORD_BITS-1:0] vec_x       = '0;
    logic [COORD_BITS-1:0] vec_y       = '0;
    logic                  angle_valid;
    logic                  angle_stall = 1'b0;
    logic [ANGLE_BITS-1:0] angle;

    logic [ANGLE_BITS-1:0] atan_table [TABLE_SIZE];
    angle_expect_t         pending_angles [$];
    angle_expect_t         oldest_angle;
    int                    mismatches  = 0;
    int                    idle_cycles = 0;

    binary_angle_atan2 dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .vec_valid   (vec_valid),
        .vec_stall   (vec_stall),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .angle_valid (angle_valid),
        .angle_stall (angle_stall),
        .angle       (angle)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] q60_product(input logic [63:0] u, input logic [63:0] v);
        logic [127:0] p;
        p = {64'd0, u} * {64'd0, v};
        return p[123:60];
    endfunction

    function automatic logic [63:0] scaled_quotient(input logic [63:0] n, input logic [63:0] d,
                                                    input int bits);
        logic [127:0] q;
        q = ({64'd0, n} << bits) / {64'd0, d};
        return q[63:0];
    endfunction

    function automatic logic [ANGLE_BITS-1:0] atan_code(input logic [63:0] i);
        logic [63:0] a2;
        logic [63:0] s2;
        logic [63:0] pref;
        logic [63:0] yq;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] res;
        if (i == 64'd0)
        begin
            return '0;
        end
        a2   = i * i;
        s2   = a2 + 64'(TABLE_SIZE) * 64'(TABLE_SIZE);
        pref = scaled_quotient(i * 64'(TABLE_SIZE), s2, FRAC_BITS);
        yq   = scaled_quotient(a2, s2, FRAC_BITS);
        term = 64'd1 << FRAC_BITS;
        sum  = term;
        for (int n = 1; n <= SERIES_CAP && term != 64'd0; n++)
        begin
            term = q60_product(term, yq);
            term = term - term / 64'(2 * n + 1);
            sum  = sum + term;
        end
        res = scaled_quotient(q60_product(pref, sum), PI_Q60, ANGLE_BITS - 1);
        return res[ANGLE_BITS-1:0];
    endfunction

    function automatic logic [ANGLE_BITS-1:0] predict_angle(input logic [COORD_BITS-1:0] x,
                                                            input logic [COORD_BITS-1:0] y);
        logic [63:0]           ax;
        logic [63:0]           ay;
        logic [63:0]           mn;
        logic [63:0]           mx;
        logic [63:0]           idx;
        logic [ANGLE_BITS-1:0] a;
        ax = x[COORD_BITS-1] ? (64'd1 << COORD_BITS) - 64'(x) : 64'(x);
        ay = y[COORD_BITS-1] ? (64'd1 << COORD_BITS) - 64'(y) : 64'(y);
        if (ax == 64'd0 && ay == 64'd0)
        begin
            return '0;
        end
        if (ay == 64'd0)
        begin
            a = '0;
        end
        else if (ay == ax)
        begin
            a = ANG_EIGHTH;
        end
        else if (ax == 64'd0)
        begin
            a = ANG_QUARTER;
        end
        else
        begin
            mn  = (ay > ax) ? ax : ay;
            mx  = (ay > ax) ? ay : ax;
            idx = mn * 64'(TABLE_SIZE) / mx;
            if (idx > 64'(TABLE_SIZE - 1))
            begin
                idx = 64'(TABLE_SIZE - 1);
            end
            a = atan_table[idx];
            if (ay > ax)
            begin
                a = ANG_QUARTER - a;
            end
        end
        if (x[COORD_BITS-1])
        begin
            a = ANG_HALF - a;
        end
        if (y[COORD_BITS-1])
        begin
            a = '0 - a;
        end
        return a;
    endfunction

    task automatic pick_vector(output logic [COORD_BITS-1:0] x, output logic [COORD_BITS-1:0] y);
        int unsigned kind;
        logic [63:0] mx;
        logic [63:0] mn;
        logic [63:0] mag_x;
        logic [63:0] mag_y;
        logic        swap;
        kind = $urandom_range(0, 9);
        if (kind <= 2)
        begin
            x = $urandom;
            y = $urandom;
            return;
        end
        if (kind == 3)
        begin
            x = 32'($urandom_range(0, 4000)) - 32'd2000;
            y = 32'($urandom_range(0, 4000)) - 32'd2000;
            return;
        end
        mx = 64'($urandom & 32'h7FFF_FFFF) >> $urandom_range(0, 31);
        if ($urandom_range(0, 15) == 0)
        begin
            mx = 64'd1 << (COORD_BITS - 1);
        end
        if (mx == 64'd0)
        begin
            mx = 64'd1;
        end
        if (kind <= 5)
        begin
            mn = mx - 64'($urandom_range(0, 3));
            if (mn > mx)
            begin
                mn = mx;
            end
        end
        else if (kind == 6)
        begin
            mn = 64'd0;
        end
        else
        begin
            mn = mx * 64'($urandom_range(0, TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
            mn = mn + 64'($urandom_range(0, 1));
            if (mn > mx)
            begin
                mn = mx;
            end
        end
        swap  = 1'($urandom_range(0, 1));
        mag_x = swap ? mn : mx;
        mag_y = swap ? mx : mn;
        x = $urandom_range(0, 1) ? 32'(64'd0 - mag_x) : mag_x[COORD_BITS-1:0];
        y = $urandom_range(0, 1) ? 32'(64'd0 - mag_y) : mag_y[COORD_BITS-1:0];
    endtask

    task automatic offer_vector(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                                input logic [ANGLE_BITS-1:0] expected);
        vec_valid <= 1'b1;
        vec_x     <= x;
        vec_y     <= y;
        do
        begin
            @(posedge clk);
        end
        while (vec_stall);
        pending_angles.push_back('{x, y, expected});
    endtask

    initial
    begin
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        int                    sent;
        int                    burst;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            atan_table[i] = atan_code(64'(i));
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            x = DIRECTED_VECTORS[i].x;
            y = DIRECTED_VECTORS[i].y;
            offer_vector(x, y, DIRECTED_VECTORS[i].known ? DIRECTED_VECTORS[i].angle
                                                         : predict_angle(x, y));
        end
        vec_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        sent = 0;
        while (sent < RANDOM_VECTORS)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++)
            begin
                pick_vector(x, y);
                offer_vector(x, y, predict_angle(x, y));
                sent++;
            end
            vec_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        while (pending_angles.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("binary_angle_atan2: match");
        end
        else
        begin
            $display("binary_angle_atan2: mismatch");
        end
        $finish;
    end

    // The receiver opens with a long hold-off so that the directed transactions back up.
    initial
    begin
        rx_mode_t mode;
        int       len;
        logic     hold;
        mode = RX_HOLD_OFF;
        len  = FIRST_HOLD_OFF;
        wait (rst_n);
        forever
        begin
            for (int c = 0; c < len; c++)
            begin
                case (mode)
                    RX_FREE:     hold = 1'b0;
                    RX_RANDOM:   hold = 1'($urandom_range(0, 1));
                    RX_HEAVY:    hold = ($urandom_range(0, 4) != 0);
                    RX_PERIODIC: hold = (c % 3 == 0);
                    default:     hold = 1'b1;
                endcase
                angle_stall <= hold;
                @(posedge clk);
            end
            case ($urandom_range(0, 9))
                0, 1, 2: mode = RX_FREE;
                3, 4, 5: mode = RX_RANDOM;
                6:       mode = RX_HEAVY;
                7, 8:    mode = RX_PERIODIC;
                default: mode = RX_HOLD_OFF;
            endcase
            len = (mode == RX_HOLD_OFF) ? $urandom_range(40, 100) : $urandom_range(10, 200);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && angle_valid && !angle_stall)
        begin
            if (pending_angles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("unexpected angle %0d with no transaction outstanding", angle);
                end
            end
            else
            begin
                oldest_angle = pending_angles.pop_front();
                if (angle !== oldest_angle.angle)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("angle wrong for x=%h y=%h: expected %0d, got %0d",
                                 oldest_angle.x, oldest_angle.y, oldest_angle.angle, angle);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (vec_valid && !vec_stall) || (angle_valid && !angle_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("binary_angle_atan2: mismatch");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
